FILE: sv/sav_pkg.sv
// ----------------------------------------------------------------------------
// sav_pkg
// Shared types, widths and the CORDIC arctangent table for the signed angle
// pipeline.
// ----------------------------------------------------------------------------
package sav_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int CORDIC_STAGES   = 16;
  localparam int ANGLE_WIDTH     = 16;

  localparam int DIFF_W  = COORD_WIDTH + 1;   // point difference
  localparam int PROD_W  = 2 * DIFF_W;        // single product
  localparam int CROSS_W = PROD_W + 1;        // cross component
  localparam int DOT_W   = PROD_W + 2;        // dot product
  localparam int SCL_W   = 32;                // after joint scaling
  localparam int SQ_W    = 2 * SCL_W;         // square sum
  localparam int ROOT_W  = SQ_W / 2;          // root bits, one per sqrt cell
  localparam int IDX_W   = 5;                 // sqrt / CORDIC step index
  localparam int SH_W    = 3;                 // joint scale shift
  localparam int XY_W    = SCL_W + 4;         // CORDIC x / y with growth
  localparam int Z_W     = 34;                // Q4.30 accumulator
  localparam int R_W     = 36;                // fold / round

  localparam logic signed [R_W-1:0] PI_Q30    = 36'sd3373259426;
  localparam logic signed [R_W-1:0] ROUND_ADD = R_W'(64'sd1 <<< (29 - ANGLE_FRAC_BITS));
  localparam int                    ROUND_SH  = 30 - ANGLE_FRAC_BITS;
  localparam int                    ANGLE_MAX = 25736;

  typedef struct packed {
    logic valid;
    logic degen;   // zero-length vector
    logic dneg;    // dot product negative
    logic cneg;    // cross z negative
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [SQ_W-1:0]   rem;
    logic [ROOT_W-1:0] root;
    logic [SCL_W-1:0]  dabs;
  } sqrt_stage_t;

  typedef struct packed {
    side_t                  side;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_stage_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic signed [Z_W-1:0] atan_q30(input logic [IDX_W-1:0] i);
    logic [Z_W-1:0] one_sh;
    one_sh = '0;
    unique case (i)
      5'd0:  return 34'sd843314856;
      5'd1:  return 34'sd497837829;
      5'd2:  return 34'sd263043836;
      5'd3:  return 34'sd133525158;
      5'd4:  return 34'sd67021686;
      5'd5:  return 34'sd33543515;
      5'd6:  return 34'sd16775850;
      5'd7:  return 34'sd8388437;
      5'd8:  return 34'sd4194282;
      5'd9:  return 34'sd2097149;
      5'd10: return 34'sd1048575;
      5'd31: return '0;
      default: begin
        one_sh = 34'd1 << (5'd30 - i);
        return $signed(one_sh - 34'd1);
      end
    endcase
  endfunction

endpackage

FILE: sv/sav_sqrt_cell.sv
// ----------------------------------------------------------------------------
// sav_sqrt_cell
// One digit of the integer square root: decides root bit k and passes the
// remainder on.
// ----------------------------------------------------------------------------
module sav_sqrt_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic [sav_pkg::IDX_W-1:0]  k,
  input  sav_pkg::sqrt_stage_t       stage_in,
  output sav_pkg::sqrt_stage_t       stage_out
);

  sav_pkg::sqrt_stage_t       stage_next;
  logic [sav_pkg::SQ_W-1:0]   root_ext;
  logic [sav_pkg::SQ_W-1:0]   trial;

  // rem = v - root^2; trial = (root + 2^k)^2 - root^2
  always_comb begin
    stage_next = stage_in;
    root_ext   = sav_pkg::SQ_W'(stage_in.root);
    trial      = (root_ext << (6'(k) + 6'd1)) | (64'd1 << {k, 1'b0});
    if (stage_in.rem >= trial) begin
      stage_next.rem  = stage_in.rem - trial;
      stage_next.root = stage_in.root | (sav_pkg::ROOT_W'(1) << k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.side.valid <= 1'b0;
    end else if (adv) begin
      stage_out <= stage_next;
    end
  end

endmodule

FILE: sv/sav_cordic_cell.sv
// ----------------------------------------------------------------------------
// sav_cordic_cell
// One vectoring-mode CORDIC step: rotates toward y = 0 and accumulates angle.
// ----------------------------------------------------------------------------
module sav_cordic_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic [sav_pkg::IDX_W-1:0]  i,
  input  sav_pkg::cordic_stage_t     stage_in,
  output sav_pkg::cordic_stage_t     stage_out
);

  sav_pkg::cordic_stage_t             stage_next;
  logic signed [sav_pkg::XY_W-1:0]    xs;
  logic signed [sav_pkg::XY_W-1:0]    ys;
  logic signed [sav_pkg::Z_W-1:0]     step_ang;

  // y == 0: pass through unchanged
  always_comb begin
    stage_next = stage_in;
    xs         = stage_in.x >>> i;
    ys         = stage_in.y >>> i;
    step_ang   = sav_pkg::atan_q30(i);
    if (stage_in.y > 0) begin
      stage_next.x = stage_in.x + ys;
      stage_next.y = stage_in.y - xs;
      stage_next.z = stage_in.z + step_ang;
    end else if (stage_in.y < 0) begin
      stage_next.x = stage_in.x - ys;
      stage_next.y = stage_in.y + xs;
      stage_next.z = stage_in.z - step_ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.side.valid <= 1'b0;
    end else if (adv) begin
      stage_out <= stage_next;
    end
  end

endmodule

FILE: sv/signed_angle_3d_vectors.sv
// ----------------------------------------------------------------------------
// signed_angle_3d_vectors
// Signed angle at a vertex between two 3D points, Q3.13 radians.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one transfer carries first point, vertex and second
//   point, nine signed 16-bit coordinates in mm.
//   Master stream m_*: one transfer per input, angle in tdata (Q3.13,
//   -pi..pi) and a degenerate flag in tuser (zero-length vector, angle 0).
//   The pipeline has 7 front-end stages (difference, products, sums,
//   scale detect, scale shift, squares, square sum), 32 square-root cells
//   (one root bit each), 16 CORDIC cells and the output register.
//   Throughput is one transfer per cycle while the receiver does not stall;
//   every stage is a register slice advancing together.
//   When the receiver stalls with a result held, the whole chain freezes
//   and s_tready drops; it resumes the cycle the result is taken.
//   Reset clears every stage valid bit and the output valid; the datapath
//   holds no state between items.
// ----------------------------------------------------------------------------
module signed_angle_3d_vectors (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // first_x, first_y, first_z, origin_x, origin_y, origin_z,
  // second_x, second_y, second_z (16 bits each)
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [15:0]  m_tdata,   // angle
  output logic [0:0]   m_tuser    // degenerate
);

  localparam int CW = sav_pkg::COORD_WIDTH;

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // ---- stage 1: difference vectors -----------------------------------------
  logic signed [sav_pkg::DIFF_W-1:0] a_c [3];
  logic signed [sav_pkg::DIFF_W-1:0] b_c [3];
  logic signed [sav_pkg::DIFF_W-1:0] a1  [3];
  logic signed [sav_pkg::DIFF_W-1:0] b1  [3];
  sav_pkg::side_t                    side1;
  sav_pkg::side_t                    side_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a_c[k] = sav_pkg::DIFF_W'($signed(s_tdata[k*CW +: CW]))
             - sav_pkg::DIFF_W'($signed(s_tdata[(3+k)*CW +: CW]));
      b_c[k] = sav_pkg::DIFF_W'($signed(s_tdata[(6+k)*CW +: CW]))
             - sav_pkg::DIFF_W'($signed(s_tdata[(3+k)*CW +: CW]));
    end
    side_c       = '0;
    side_c.valid = s_tvalid;
    side_c.degen = (a_c[0] == 0 && a_c[1] == 0 && a_c[2] == 0) ||
                   (b_c[0] == 0 && b_c[1] == 0 && b_c[2] == 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side1.valid <= 1'b0;
    end else if (adv) begin
      side1 <= side_c;
      a1    <= a_c;
      b1    <= b_c;
    end
  end

  // ---- stage 2: nine products ----------------------------------------------
  // p[0..5]: cross terms y1z2 z1y2 z1x2 x1z2 x1y2 y1x2; p[6..8]: dot terms
  logic signed [sav_pkg::PROD_W-1:0] p2 [9];
  sav_pkg::side_t                    side2;

  always_ff @(posedge clk) begin
    if (rst) begin
      side2.valid <= 1'b0;
    end else if (adv) begin
      side2 <= side1;
      p2[0] <= a1[1] * b1[2];
      p2[1] <= a1[2] * b1[1];
      p2[2] <= a1[2] * b1[0];
      p2[3] <= a1[0] * b1[2];
      p2[4] <= a1[0] * b1[1];
      p2[5] <= a1[1] * b1[0];
      p2[6] <= a1[0] * b1[0];
      p2[7] <= a1[1] * b1[1];
      p2[8] <= a1[2] * b1[2];
    end
  end

  // ---- stage 3: cross and dot ----------------------------------------------
  logic signed [sav_pkg::CROSS_W-1:0] c3r [3];
  logic signed [sav_pkg::DOT_W-1:0]   d3;
  sav_pkg::side_t                     side3;
  sav_pkg::side_t                     side3_next;
  logic signed [sav_pkg::CROSS_W-1:0] cz_next;

  always_comb begin
    cz_next         = sav_pkg::CROSS_W'(p2[4]) - sav_pkg::CROSS_W'(p2[5]);
    side3_next      = side2;
    side3_next.cneg = cz_next < 0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side3.valid <= 1'b0;
    end else if (adv) begin
      side3  <= side3_next;
      c3r[0] <= sav_pkg::CROSS_W'(p2[0]) - sav_pkg::CROSS_W'(p2[1]);
      c3r[1] <= sav_pkg::CROSS_W'(p2[2]) - sav_pkg::CROSS_W'(p2[3]);
      c3r[2] <= cz_next;
      d3     <= sav_pkg::DOT_W'(p2[6]) + sav_pkg::DOT_W'(p2[7])
              + sav_pkg::DOT_W'(p2[8]);
    end
  end

  // ---- stage 4: joint scale detect -----------------------------------------
  // OR of magnitudes has the same top bit as their maximum
  logic [sav_pkg::DOT_W-1:0]          mag_or;
  logic [sav_pkg::SH_W-1:0]           t_c;
  logic [sav_pkg::SH_W-1:0]           t4;
  logic signed [sav_pkg::CROSS_W-1:0] c4 [3];
  logic signed [sav_pkg::DOT_W-1:0]   d4;
  sav_pkg::side_t                     side4;

  always_comb begin
    mag_or = d3 < 0 ? $unsigned(-d3) : $unsigned(d3);
    for (int k = 0; k < 3; k++) begin
      mag_or = mag_or | sav_pkg::DOT_W'(c3r[k] < 0 ? $unsigned(-c3r[k])
                                                   : $unsigned(c3r[k]));
    end
    t_c = '0;
    for (int b = 31; b < sav_pkg::DOT_W; b++) begin
      if (mag_or[b]) t_c = sav_pkg::SH_W'(b - 30);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side4.valid <= 1'b0;
    end else if (adv) begin
      side4 <= side3;
      t4    <= t_c;
      c4    <= c3r;
      d4    <= d3;
    end
  end

  // ---- stage 5: joint scale shift ------------------------------------------
  logic signed [sav_pkg::SCL_W-1:0] c5 [3];
  logic signed [sav_pkg::SCL_W-1:0] d5;
  sav_pkg::side_t                   side5;
  sav_pkg::side_t                   side5_next;

  always_comb begin
    side5_next      = side4;
    side5_next.dneg = d4 < 0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side5.valid <= 1'b0;
    end else if (adv) begin
      side5 <= side5_next;
      for (int k = 0; k < 3; k++) begin
        c5[k] <= sav_pkg::SCL_W'(c4[k] >>> t4);
      end
      d5 <= sav_pkg::SCL_W'(d4 >>> t4);
    end
  end

  // ---- stage 6: squares ----------------------------------------------------
  logic [sav_pkg::SQ_W-1:0]  sq6 [3];
  logic [sav_pkg::SCL_W-1:0] dabs6;
  sav_pkg::side_t            side6;

  always_ff @(posedge clk) begin
    if (rst) begin
      side6.valid <= 1'b0;
    end else if (adv) begin
      side6 <= side5;
      for (int k = 0; k < 3; k++) begin
        sq6[k] <= $unsigned(sav_pkg::SQ_W'(c5[k]) * sav_pkg::SQ_W'(c5[k]));
      end
      dabs6 <= d5[sav_pkg::SCL_W-1] ? $unsigned(-d5) : $unsigned(d5);
    end
  end

  // ---- stage 7: square sum, head of the root chain -------------------------
  sav_pkg::sqrt_stage_t sq_chain [sav_pkg::ROOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_chain[0].side.valid <= 1'b0;
    end else if (adv) begin
      sq_chain[0].side <= side6;
      sq_chain[0].rem  <= sq6[0] + sq6[1] + sq6[2];
      sq_chain[0].root <= '0;
      sq_chain[0].dabs <= dabs6;
    end
  end

  // ---- root cells, most significant bit first ------------------------------
  for (genvar g = 0; g < sav_pkg::ROOT_W; g++) begin : g_sqrt
    sav_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .k         (sav_pkg::IDX_W'(sav_pkg::ROOT_W - 1 - g)),
      .stage_in  (sq_chain[g]),
      .stage_out (sq_chain[g+1])
    );
  end

  // ---- CORDIC cells: x = |d|, y = |c| --------------------------------------
  sav_pkg::cordic_stage_t cd_chain [sav_pkg::CORDIC_STAGES+1];

  always_comb begin
    cd_chain[0].side = sq_chain[sav_pkg::ROOT_W].side;
    cd_chain[0].x    = sav_pkg::XY_W'(sq_chain[sav_pkg::ROOT_W].dabs);
    cd_chain[0].y    = sav_pkg::XY_W'(sq_chain[sav_pkg::ROOT_W].root);
    cd_chain[0].z    = '0;
  end

  for (genvar g = 0; g < sav_pkg::CORDIC_STAGES; g++) begin : g_cordic
    sav_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .i         (sav_pkg::IDX_W'(g)),
      .stage_in  (cd_chain[g]),
      .stage_out (cd_chain[g+1])
    );
  end

  // ---- fold, clamp, round, sign: output register ---------------------------
  sav_pkg::cordic_stage_t              fin;
  logic signed [sav_pkg::R_W-1:0]      r_fold;
  logic signed [sav_pkg::R_W-1:0]      r_clamp;
  logic signed [sav_pkg::R_W-1:0]      r_round;
  logic signed [sav_pkg::R_W-1:0]      r_sign;
  logic [sav_pkg::ANGLE_WIDTH-1:0]     angle_next;

  always_comb begin
    fin     = cd_chain[sav_pkg::CORDIC_STAGES];
    r_fold  = fin.side.dneg ? sav_pkg::PI_Q30 - sav_pkg::R_W'(fin.z)
                            : sav_pkg::R_W'(fin.z);
    r_clamp = r_fold;
    if (r_fold < 0) begin
      r_clamp = '0;
    end else if (r_fold > sav_pkg::PI_Q30) begin
      r_clamp = sav_pkg::PI_Q30;
    end
    r_round    = (r_clamp + sav_pkg::ROUND_ADD) >>> sav_pkg::ROUND_SH;
    r_sign     = fin.side.cneg ? -r_round : r_round;
    angle_next = fin.side.degen ? '0 : r_sign[sav_pkg::ANGLE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid   <= fin.side.valid;
      m_tdata    <= angle_next;
      m_tuser[0] <= fin.side.degen;
    end
  end

  // ---- checks --------------------------------------------------------------
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("degenerate result with nonzero angle");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata) <= sav_pkg::ANGLE_MAX &&
                  $signed(m_tdata) >= -sav_pkg::ANGLE_MAX))
    else $error("angle outside -pi..pi");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(fin.side.valid) && $stable(fin.z))
    else $error("pipeline moved during stall");

endmodule

FILE: bench/tb_signed_angle_3d_vectors.sv
// ----------------------------------------------------------------------------
// tb_signed_angle_3d_vectors
// Self-checking bench for the signed 3D vertex angle pipeline. A driver and a
// monitor run as clocked processes. Each transfer is scored against a local
// fixed-point model of the difference, cross/dot, joint scale, root and
// CORDIC datapath. Both sides idle in random bursts, and the receiver holds
// off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_signed_angle_3d_vectors;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int    TOTAL_RAND = 1150;
  localparam int    WATCHDOG   = 4000;
  localparam longint PI30      = 64'sd3373259426;

  typedef struct packed {
    logic [15:0] angle;
    logic        degen;
  } angle_res_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [15:0]  m_tdata;
  logic [0:0]   m_tuser;

  signed_angle_3d_vectors DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [143:0] pending_q[$];    // triples not yet accepted
  angle_res_t   angle_exp_q[$];  // predicted angles, oldest first
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;              // no idling in the final part
  int  src_gap = 0;
  int  snk_gap = 0;
  int  holdoff = 0;
  bit  holdoff_armed = 1'b0;
  int  accepted = 0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint labs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint atan_q30(int i);
    longint head[11] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                         33543515, 16775850, 8388437, 4194282, 2097149, 1048575};
    if (i <= 10) return head[i];
    if (i <= 30) return (64'sd1 <<< (30 - i)) - 1;
    return 0;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned op, res, one;
    op = v; res = 0; one = 64'd1 << 62;
    while (one > op) one >>= 2;
    while (one != 0) begin
      if (op >= res + one) begin
        op -= res + one;
        res = (res >> 1) + one;
      end else begin
        res >>= 1;
      end
      one >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic angle_res_t vertex_angle(logic [143:0] td);
    longint a[3], b[3], c1, c2, c3, d, m, x, y, z, xs, ys, r;
    int t;
    bit neg;
    angle_res_t res;
    for (int k = 0; k < 3; k++) begin
      longint o;
      o = longint'($signed(td[16*(3+k) +: 16]));
      a[k] = longint'($signed(td[16*k +: 16])) - o;
      b[k] = longint'($signed(td[16*(6+k) +: 16])) - o;
    end
    res = '0;
    if ((a[0] == 0 && a[1] == 0 && a[2] == 0) || (b[0] == 0 && b[1] == 0 && b[2] == 0)) begin
      res.degen = 1'b1;
      return res;
    end
    // differences fit 17 bits, so no per-vector scaling is applied here
    c1 = a[1]*b[2] - a[2]*b[1];
    c2 = a[2]*b[0] - a[0]*b[2];
    c3 = a[0]*b[1] - a[1]*b[0];
    d  = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
    neg = c3 < 0;
    m = labs(c1);
    if (labs(c2) > m) m = labs(c2);
    if (labs(c3) > m) m = labs(c3);
    if (labs(d) > m) m = labs(d);
    t = 0;
    while (t < 62 && (m >> t) >= (64'sd1 <<< 31)) t++;
    c1 = floor_shr(c1, t); c2 = floor_shr(c2, t);
    c3 = floor_shr(c3, t); d = floor_shr(d, t);
    m = int_sqrt(longint'(c1*c1) + longint'(c2*c2) + longint'(c3*c3));
    x = labs(d); y = m; z = 0;
    for (int i = 0; i < 16; i++) begin
      xs = floor_shr(x, i); ys = floor_shr(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += atan_q30(i);
      end else if (y < 0) begin
        x -= ys; y += xs; z -= atan_q30(i);
      end
    end
    r = (d < 0) ? PI30 - z : z;
    if (r < 0) r = 0;
    if (r > PI30) r = PI30;
    r = (r + (64'sd1 <<< 16)) >>> 17;
    if (neg) r = -r;
    res.angle = r[15:0];
    return res;
  endfunction

  function automatic logic [143:0] pack_pts(longint p[9]);
    logic [143:0] v;
    for (int k = 0; k < 9; k++) v[16*k +: 16] = p[k][15:0];
    return v;
  endfunction

  function automatic void queue_pts(longint p[9]);
    pending_q.insert(pending_q.size(), pack_pts(p));
  endfunction

  // Driver: one nonblocking update per edge; valid stays up across transfers.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        angle_exp_q.insert(angle_exp_q.size(), vertex_angle(s_tdata));
        void'(pending_q.pop_front());
      end
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        s_tvalid <= 1'b0;
      end else if (!calm && !(s_tvalid && !s_tready) && $urandom_range(0, 15) == 0) begin
        src_gap <= $urandom_range(1, 5) - 1;
        s_tvalid <= 1'b0;
      end else if (pending_q.size() > (s_tvalid && s_tready ? 0 : 0)) begin
        s_tvalid <= pending_q.size() > 0;
        if (pending_q.size() > 0) s_tdata <= pending_q[0];
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: scores transfers, paces the receiver, runs the watchdog.
  always @(posedge clk) begin
    angle_res_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.angle = m_tdata;
        got.degen = m_tuser[0];
        if (angle_exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result angle=%0d degen=%0b",
                                         $signed(got.angle), got.degen);
        end else begin
          want = angle_exp_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected angle=%0d degen=%0b, got angle=%0d degen=%0b",
                       $signed(want.angle), want.degen, $signed(got.angle), got.degen);
          end
        end
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("simulation failed");
        $finish;
      end
      // long hold-off once the random part is under way
      if (!holdoff_armed && accepted > 300) begin
        holdoff_armed <= 1'b1;
        holdoff <= 200;
        m_tready <= 1'b0;
      end else if (holdoff > 0) begin
        holdoff <= holdoff - 1;
        m_tready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        snk_gap <= $urandom_range(1, 5) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
      if (s_tvalid && s_tready) accepted <= accepted + 1;
    end
  end

  initial begin
    longint p[9];
    int kind;
    // directed: extremes, degenerate, parallel, antiparallel, perpendicular
    for (int k = 0; k < 9; k++) p[k] = 0;
    queue_pts(p);                                            // all zero
    p = '{5, 0, 0, 0, 0, 0, 0, 0, 0}; queue_pts(p);
    p = '{0, 0, 0, 0, 0, 0, 3, 4, 5}; queue_pts(p);
    p = '{1, 2, 3, 0, 0, 0, 2, 4, 6}; queue_pts(p);
    p = '{1, 2, 3, 0, 0, 0, -2, -4, -6}; queue_pts(p);
    p = '{1, 0, 0, 0, 0, 0, 0, 1, 0}; queue_pts(p);
    p = '{0, 1, 0, 0, 0, 0, 1, 0, 0}; queue_pts(p);
    p = '{0, 0, 7, 0, 0, 0, 9, 0, 0}; queue_pts(p);
    p = '{32767, 32767, 32767, -32768, -32768, -32768, 32767, 32767, 32767};
    queue_pts(p);
    p = '{32767, -32768, 32767, -32768, 32767, -32768, -32768, -32768, 32767};
    queue_pts(p);
    p = '{-32768, 32767, 0, 32767, -32768, 0, 32767, 32767, -32768};
    queue_pts(p);
    p = '{32767, -32768, 0, -32768, 32767, 0, -32768, -32768, 32767};
    queue_pts(p);
    p = '{-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, -32768};
    queue_pts(p);
    p = '{100, 100, 100, 100, 100, 100, 200, 100, 100}; queue_pts(p);
    p = '{1, 0, 0, 0, 0, 0, -1, 1, 0}; queue_pts(p);
    p = '{1, 0, 0, 0, 0, 0, -1, -1, 0}; queue_pts(p);
    p = '{-1, 0, 0, 0, 0, 0, 1, 0, 0}; queue_pts(p);
    for (int n = 0; n < TOTAL_RAND; n++) begin
      kind = $urandom_range(0, 9);
      for (int k = 0; k < 9; k++) p[k] = $signed(16'($urandom()));
      if (kind == 0) begin
        for (int k = 0; k < 3; k++) p[k] = p[3+k];          // zero first vector
      end else if (kind == 1) begin
        for (int k = 0; k < 3; k++) p[6+k] = p[3+k] + $signed(4'($urandom()));
      end else if (kind <= 3) begin
        // small vectors near the vertex: random, and exactly parallel for kind 3
        for (int k = 0; k < 9; k++) p[k] = $signed(6'($urandom()));
        if (kind == 3) for (int k = 0; k < 3; k++) p[6+k] = 2*p[k] - p[3+k];
      end
      queue_pts(p);
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (pending_q.size() < 100);
    calm = 1'b1;
    wait (pending_q.size() == 0 && !s_tvalid);
    wait (angle_exp_q.size() == 0);
    repeat (80) @(posedge clk);
    if (mismatches == 0 && angle_exp_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
sv/sav_pkg.sv
sv/sav_sqrt_cell.sv
sv/sav_cordic_cell.sv
sv/signed_angle_3d_vectors.sv
bench/tb_signed_angle_3d_vectors.sv
